// ----- rtl/core/complementary_pitch_filter_defines.svh -----
// assertion helpers for the pitch filter
`ifndef COMPLEMENTARY_PITCH_FILTER_DEFINES_SVH
`define COMPLEMENTARY_PITCH_FILTER_DEFINES_SVH

// same-cycle implication
`define CPF_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CPF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/cpf_pkg.sv -----
package cpf_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GYRO_DIV    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_G_SQUARED   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_THR   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_ORDER = 3'd4;

    localparam logic [9:0]  ALPHA_RST     = 10'd10;
    localparam logic [14:0] GYRO_DIV_RST  = 15'd1;
    localparam logic [14:0] G_SQUARED_RST = 15'd3969;
    localparam logic [15:0] ACCEL_THR_RST = 16'd5953;

    localparam int BLEND_FULL = 512;
    localparam int BLEND_SH   = 9;
    localparam int BLEND_W    = 27;
    localparam int RECIP6     = 43691;
    localparam int RECIP6_SH  = 18;
    localparam int MUL_W      = 18;

    localparam int DIV_N = 32;
    localparam int DIV_D = 15;

    typedef struct packed {
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_z;
        logic signed [15:0] gyro_y;
    } t_in_word;

    typedef struct packed {
        logic signed [15:0] pitch;
        logic               accel_used;
    } t_out_word;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_SQ,
        OP_GTERM,
        OP_MQ6,
        OP_MCOR,
        OP_CDIV,
        OP_CSAT,
        OP_MB1,
        OP_MB2,
        OP_MB3,
        OP_FIN
    } t_dp_op;

    typedef struct packed {
        logic   load;
        t_dp_op op;
    } t_dp_cmd;

    typedef struct packed {
        logic div_busy;
        logic used;
        logic first_order;
        logic out_free;
    } t_dp_status;

    function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
        logic signed [15:0] r;
        if (v > 18'sd32767) begin
            r = 16'sh7FFF;
        end else if (v < -18'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

endpackage

// ----- rtl/core/cpf_div.sv -----
module cpf_div
    import cpf_pkg::*;
#(
    parameter int DIVIDEND_W = DIV_N,
    parameter int DIVISOR_W  = DIV_D
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [DIVIDEND_W-1:0] i_dividend,
    input  logic [DIVISOR_W-1:0]  i_divisor,
    output logic                  o_busy,
    output logic [DIVIDEND_W-1:0] o_quotient
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic [CNT_W-1:0]      r_count;
    logic [DIVIDEND_W-1:0] r_quo;
    logic [DIVISOR_W-1:0]  r_rem;
    logic [DIVISOR_W-1:0]  r_divisor;
    logic [DIVISOR_W:0]    shifted;
    logic [DIVISOR_W:0]    diff;

    // one restoring step per cycle, msb first
    assign shifted = {r_rem, r_quo[DIVIDEND_W-1]};
    assign diff    = shifted - {1'b0, r_divisor};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_start) begin
            r_count <= CNT_W'(DIVIDEND_W);
        end else if (r_count != '0) begin
            r_count <= r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo     <= i_dividend;
            r_rem     <= '0;
            r_divisor <= i_divisor;
        end else if (r_count != '0) begin
            if (!diff[DIVISOR_W]) begin
                r_rem <= diff[DIVISOR_W-1:0];
                r_quo <= {r_quo[DIVIDEND_W-2:0], 1'b1};
            end else begin
                r_rem <= shifted[DIVISOR_W-1:0];
                r_quo <= {r_quo[DIVIDEND_W-2:0], 1'b0};
            end
        end
    end

    assign o_busy     = (r_count != '0);
    assign o_quotient = r_quo;

endmodule

// ----- rtl/core/cpf_datapath.sv -----
module cpf_datapath
    import cpf_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  t_in_word              i_in_data,
    input  logic                  i_out_stall,
    input  t_dp_cmd               i_cmd,
    output t_dp_status            o_status,
    output logic                  o_out_valid,
    output t_out_word             o_out_data
);

    localparam int BQ_W = BLEND_W - BLEND_SH;

    logic [9:0]  r_alpha;
    logic [14:0] r_gdiv;
    logic [14:0] r_g2;
    logic [15:0] r_thr;
    logic        r_first;

    logic signed [15:0] r_pitch;
    logic signed [7:0]  r_ax;
    logic signed [7:0]  r_ay;
    logic signed [7:0]  r_az;
    logic signed [15:0] r_gy;
    logic [14:0]        r_ax2;
    logic [16:0]        r_a2;
    logic               r_used;
    logic signed [15:0] r_gterm;
    logic signed [15:0] r_acc;
    logic signed [2*MUL_W-1:0] r_prod;
    logic signed [BLEND_W-1:0] r_blend;
    logic               r_out_valid;
    t_out_word          r_out;

    logic signed [15:0] sq_x;
    logic signed [15:0] sq_y;
    logic signed [15:0] sq_z;
    logic [9:0]         alpha_eff;
    logic [9:0]         alpha_inv;
    logic [14:0]        gdiv_eff;
    logic [14:0]        g2_eff;
    logic [11:0]        q6;
    logic [15:0]        cor_fac;
    logic [15:0]        acc_mag;
    logic [15:0]        gy_mag;
    logic [17:0]        gq_ext;
    logic [17:0]        gq;
    logic signed [17:0] gsum;
    logic signed [15:0] csat;
    logic signed [BQ_W-1:0] bq;
    logic signed [15:0] new_pitch;
    logic signed [MUL_W-1:0]   mul_a;
    logic signed [MUL_W-1:0]   mul_b;
    logic signed [2*MUL_W-1:0] mul_p;
    logic               div_start;
    logic [DIV_N-1:0]   div_dividend;
    logic [DIV_D-1:0]   div_divisor;
    logic               div_busy;
    logic [DIV_N-1:0]   div_quo;
    logic               out_take;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha <= ALPHA_RST;
            r_gdiv  <= GYRO_DIV_RST;
            r_g2    <= G_SQUARED_RST;
            r_thr   <= ACCEL_THR_RST;
            r_first <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_ALPHA:       r_alpha <= i_cfg_data[9:0];
                CFG_GYRO_DIV:    r_gdiv  <= i_cfg_data[14:0];
                CFG_G_SQUARED:   r_g2    <= i_cfg_data[14:0];
                CFG_ACCEL_THR:   r_thr   <= i_cfg_data;
                CFG_FIRST_ORDER: r_first <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign sq_x = r_ax * r_ax;
    assign sq_y = r_ay * r_ay;
    assign sq_z = r_az * r_az;

    assign alpha_eff = (r_alpha > 10'(BLEND_FULL)) ? 10'(BLEND_FULL) : r_alpha;
    assign alpha_inv = 10'(BLEND_FULL) - alpha_eff;
    assign gdiv_eff  = (r_gdiv == '0) ? 15'd1 : r_gdiv;
    assign g2_eff    = (r_g2 == '0) ? 15'd1 : r_g2;

    // ax^2 / 6 by reciprocal
    assign q6      = r_prod[RECIP6_SH +: 12];
    assign cor_fac = {1'b0, g2_eff} + {4'b0, q6};
    assign acc_mag = r_acc[15] ? 16'(17'd0 - {r_acc[15], r_acc}) : r_acc;
    assign gy_mag  = r_gy[15] ? 16'(17'd0 - {r_gy[15], r_gy}) : r_gy;

    // gyro term
    assign gq_ext = {2'b0, div_quo[15:0]};
    assign gq     = r_gy[15] ? (18'd0 - gq_ext) : gq_ext;
    assign gsum   = 18'(r_pitch) + $signed(gq);

    // corrected accelerometer term
    always_comb begin
        if (r_acc[15]) begin
            csat = (div_quo > DIV_N'(32768)) ? 16'sh8000 : 16'(DIV_N'(0) - div_quo);
        end else begin
            csat = (div_quo > DIV_N'(32767)) ? 16'sh7FFF : div_quo[15:0];
        end
    end

    // blend divided by 512, toward zero
    assign bq = r_blend[BLEND_W-1:BLEND_SH]
              + BQ_W'(r_blend[BLEND_W-1] && (r_blend[BLEND_SH-1:0] != '0));
    assign new_pitch = r_used ? sat16(bq) : r_gterm;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (i_cmd.op)
            OP_MQ6: begin
                mul_a = MUL_W'(r_ax2);
                mul_b = MUL_W'(RECIP6);
            end
            OP_MCOR: begin
                mul_a = MUL_W'(acc_mag);
                mul_b = MUL_W'(cor_fac);
            end
            OP_MB1: begin
                mul_a = MUL_W'(alpha_inv);
                mul_b = MUL_W'(r_gterm);
            end
            OP_MB2: begin
                mul_a = MUL_W'(alpha_eff);
                mul_b = MUL_W'(r_acc);
            end
            default: ;
        endcase
    end

    assign mul_p = mul_a * mul_b;

    assign div_start    = (i_cmd.op == OP_SQ) || (i_cmd.op == OP_CDIV);
    assign div_dividend = (i_cmd.op == OP_SQ) ? DIV_N'(gy_mag) : r_prod[DIV_N-1:0];
    assign div_divisor  = (i_cmd.op == OP_SQ) ? gdiv_eff : g2_eff;

    cpf_div #(
        .DIVIDEND_W (DIV_N),
        .DIVISOR_W  (DIV_D)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_busy     (div_busy),
        .o_quotient (div_quo)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_ax <= i_in_data.accel_x[15:8];
            r_ay <= i_in_data.accel_y[15:8];
            r_az <= i_in_data.accel_z[15:8];
            r_gy <= i_in_data.gyro_y;
        end
        case (i_cmd.op)
            OP_SQ: begin
                r_ax2 <= sq_x[14:0];
                r_a2  <= 17'(sq_x[14:0]) + 17'(sq_y[14:0]) + 17'(sq_z[14:0]);
            end
            OP_GTERM: begin
                r_gterm <= sat16(gsum);
                r_used  <= (r_a2 < {1'b0, r_thr});
                r_acc   <= {r_ax, 8'h00};
            end
            OP_MQ6, OP_MCOR, OP_MB1: r_prod <= mul_p;
            OP_CSAT: r_acc <= csat;
            OP_MB2: begin
                r_blend <= r_prod[BLEND_W-1:0];
                r_prod  <= mul_p;
            end
            OP_MB3: r_blend <= r_blend - r_prod[BLEND_W-1:0];
            OP_FIN: begin
                r_out.pitch      <= new_pitch;
                r_out.accel_used <= r_used;
            end
            default: ;
        endcase
    end

    assign out_take = r_out_valid && !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pitch     <= '0;
            r_out_valid <= 1'b0;
        end else if (i_cmd.op == OP_FIN) begin
            r_pitch     <= new_pitch;
            r_out_valid <= 1'b1;
        end else if (out_take) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_status.div_busy    = div_busy;
    assign o_status.used        = (r_a2 < {1'b0, r_thr});
    assign o_status.first_order = r_first;
    assign o_status.out_free    = !r_out_valid || !i_out_stall;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ----- rtl/core/cpf_ctrl.sv -----
module cpf_ctrl
    import cpf_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  t_dp_status i_status,
    output logic       o_stall,
    output t_dp_cmd    o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_SQ,
        S_GWAIT,
        S_GTERM,
        S_MQ6,
        S_MCOR,
        S_CDIV,
        S_CWAIT,
        S_CSAT,
        S_MB1,
        S_MB2,
        S_MB3,
        S_FIN
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd.load = 1'b0;
        o_cmd.op   = OP_NONE;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SQ;
                end
            end
            S_SQ: begin
                o_cmd.op = OP_SQ;
                n_state  = S_GWAIT;
            end
            S_GWAIT: begin
                if (!i_status.div_busy) begin
                    n_state = S_GTERM;
                end
            end
            S_GTERM: begin
                o_cmd.op = OP_GTERM;
                if (!i_status.used) begin
                    n_state = S_FIN;
                end else if (i_status.first_order) begin
                    n_state = S_MB1;
                end else begin
                    n_state = S_MQ6;
                end
            end
            S_MQ6: begin
                o_cmd.op = OP_MQ6;
                n_state  = S_MCOR;
            end
            S_MCOR: begin
                o_cmd.op = OP_MCOR;
                n_state  = S_CDIV;
            end
            S_CDIV: begin
                o_cmd.op = OP_CDIV;
                n_state  = S_CWAIT;
            end
            S_CWAIT: begin
                if (!i_status.div_busy) begin
                    n_state = S_CSAT;
                end
            end
            S_CSAT: begin
                o_cmd.op = OP_CSAT;
                n_state  = S_MB1;
            end
            S_MB1: begin
                o_cmd.op = OP_MB1;
                n_state  = S_MB2;
            end
            S_MB2: begin
                o_cmd.op = OP_MB2;
                n_state  = S_MB3;
            end
            S_MB3: begin
                o_cmd.op = OP_MB3;
                n_state  = S_FIN;
            end
            S_FIN: begin
                // hold until the output register is free
                if (i_status.out_free) begin
                    o_cmd.op = OP_FIN;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_stall = (r_state != S_IDLE);

endmodule

// ----- rtl/core/complementary_pitch_filter.sv -----
// channel   direction  handshake               word
// sample    in         i_valid / o_stall       i_data  (t_in_word)
// result    out        o_valid / i_stall       o_data  (t_out_word)
// config    in         i_cfg_we                i_cfg_index, i_cfg_data
//
// one word at a time; the result is registered in the final step and o_stall drops
// at that same edge. the shared 32-step restoring divider runs once when the
// accelerometer is not blended or takes the first-order blend, and twice with
// the second-order correction.
// synchronous active-low reset clears the stored pitch and loads register defaults.
// a waiting result in the output register does not block the next sample;
// only the final step waits while i_stall holds the previous word.
module complementary_pitch_filter
    import cpf_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  t_in_word              i_data,
    output logic                  o_valid,
    input  logic                  i_stall,
    output t_out_word             o_data,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_dp_cmd    cmd;
    t_dp_status status;

    cpf_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_status (status),
        .o_stall  (o_stall),
        .o_cmd    (cmd)
    );

    cpf_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (i_data),
        .i_out_stall (i_stall),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_valid (o_valid),
        .o_out_data  (o_data)
    );

endmodule

// ----- rtl/core/cpf_checker.sv -----
`include "complementary_pitch_filter_defines.svh"

module cpf_checker
    import cpf_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_valid,
    input logic                  o_stall,
    input logic                  o_valid,
    input logic                  i_stall,
    input t_out_word             o_data
);

    `CPF_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_valid && !o_stall, o_stall, "sample accepted but block not busy")
    `CPF_ASSERT_NOW(a_result_from_work, i_clk, i_rst_n, $rose(o_valid), $past(o_stall), "result appeared with no sample in work")
    `CPF_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_data), "stalled result dropped or changed")
    `CPF_ASSERT_NOW(a_out_drop_on_take, i_clk, i_rst_n, $fell(o_valid), $past(!i_stall), "result withdrawn without being taken")

endmodule

bind complementary_pitch_filter cpf_checker u_cpf_checker (.*);

// ----- tb/sv/tb_top.sv -----
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import cpf_pkg::*;

    localparam int ANGLE_SCALE  = 256;
    localparam int CORR_DIV     = 6;
    localparam int DRAIN_CYCLES = 100;
    localparam int PHASES       = 6;
    localparam int PHASE_WORDS  = 125;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_valid;
    logic                  o_stall;
    t_in_word              i_data;
    logic                  o_valid;
    logic                  i_stall;
    t_out_word             o_data;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    // filter state and register copies
    longint pitch_model     = 0;
    longint alpha_cfg       = longint'(ALPHA_RST);
    longint gyro_div_cfg    = longint'(GYRO_DIV_RST);
    longint g_squared_cfg   = longint'(G_SQUARED_RST);
    longint accel_thr_cfg   = longint'(ACCEL_THR_RST);
    longint first_order_cfg = 0;

    t_out_word pitch_expected[$];
    int        mismatch_count = 0;
    bit        calm = 1'b0;

    complementary_pitch_filter uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_data      (i_data),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_data      (o_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic longint clip16(input longint v);
        if (v > 32767) begin
            return 32767;
        end
        if (v < -32768) begin
            return -32768;
        end
        return v;
    endfunction

    function automatic t_out_word pitch_update(input t_in_word w);
        longint    ax, ay, az, gy, ax2, mag2, divisor, gyro_term, acc_term, weight, g2;
        t_out_word r;
        ax = longint'($signed(w.accel_x[15:8]));
        ay = longint'($signed(w.accel_y[15:8]));
        az = longint'($signed(w.accel_z[15:8]));
        gy = longint'(w.gyro_y);
        ax2 = ax * ax;
        mag2 = ay * ay + az * az + ax2;
        divisor = (gyro_div_cfg == 0) ? 1 : gyro_div_cfg;
        gyro_term = clip16(pitch_model + gy / divisor);
        r.accel_used = (mag2 < accel_thr_cfg);
        if (r.accel_used) begin
            acc_term = ANGLE_SCALE * ax;
            weight = (alpha_cfg > BLEND_FULL) ? BLEND_FULL : alpha_cfg;
            if (first_order_cfg == 0) begin
                g2 = (g_squared_cfg == 0) ? 1 : g_squared_cfg;
                acc_term = clip16(acc_term * (g2 + ax2 / CORR_DIV) / g2);
            end
            pitch_model = clip16(((BLEND_FULL - weight) * gyro_term - weight * acc_term)
                                 / BLEND_FULL);
        end else begin
            pitch_model = gyro_term;
        end
        r.pitch = pitch_model[15:0];
        return r;
    endfunction

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 85) begin
            return $urandom_range(1, 3);
        end else if (r < 97) begin
            return $urandom_range(4, 15);
        end
        return $urandom_range(30, 80);
    endfunction

    function automatic t_in_word sample_of(input logic [15:0] ax, input logic [15:0] ay,
                                           input logic [15:0] az, input int gy);
        t_in_word w;
        w.accel_x = ax;
        w.accel_y = ay;
        w.accel_z = az;
        w.gyro_y  = gy[15:0];
        return w;
    endfunction

    function automatic logic [15:0] rand_axis(input int lim);
        int hb;
        if ($urandom_range(0, 4) == 0) begin
            return 16'($urandom);
        end
        hb = int'($urandom_range(0, 2 * lim)) - lim;
        return {hb[7:0], 8'($urandom)};
    endfunction

    function automatic t_in_word rand_sample();
        t_in_word w;
        int       lim;
        int       g;
        lim = ($urandom_range(0, 3) == 0) ? 128 : $urandom_range(1, 50);
        w.accel_x = rand_axis(lim);
        w.accel_y = rand_axis(lim);
        w.accel_z = rand_axis(lim);
        case ($urandom_range(0, 3))
            0: begin
                w.gyro_y = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
            end
            1: begin
                g = int'($urandom_range(0, 128)) - 64;
                w.gyro_y = g[15:0];
            end
            default: begin
                w.gyro_y = 16'($urandom);
            end
        endcase
        return w;
    endfunction

    task automatic note_mismatch(input string what, input longint want, input longint got);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("mismatch %s: expected %0d got %0d at %0t", what, want, got, $realtime);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        logic [CFG_DATA_W-1:0] v;
        v = CFG_DATA_W'(value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_ALPHA:       alpha_cfg       = longint'(v[9:0]);
            CFG_GYRO_DIV:    gyro_div_cfg    = longint'(v[14:0]);
            CFG_G_SQUARED:   g_squared_cfg   = longint'(v[14:0]);
            CFG_ACCEL_THR:   accel_thr_cfg   = longint'(v);
            CFG_FIRST_ORDER: first_order_cfg = longint'(v[0]);
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic send_sample(input t_in_word w);
        int gap;
        gap = calm ? 0 : idle_len();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= w;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        pitch_expected.push_back(pitch_update(w));
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (pitch_expected.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic randomize_config();
        case ($urandom_range(0, 5))
            0: write_reg(CFG_ALPHA, 0);
            1: write_reg(CFG_ALPHA, BLEND_FULL);
            2: write_reg(CFG_ALPHA, $urandom_range(513, 1023));
            default: write_reg(CFG_ALPHA, $urandom_range(0, 512));
        endcase
        case ($urandom_range(0, 5))
            0: write_reg(CFG_GYRO_DIV, $urandom_range(0, 1));
            1: write_reg(CFG_GYRO_DIV, 32767);
            2: write_reg(CFG_GYRO_DIV, $urandom_range(1, 32767));
            default: write_reg(CFG_GYRO_DIV, $urandom_range(1, 300));
        endcase
        case ($urandom_range(0, 5))
            0: write_reg(CFG_G_SQUARED, $urandom_range(0, 1));
            1: write_reg(CFG_G_SQUARED, 16384);
            2: write_reg(CFG_G_SQUARED, 32767);
            default: write_reg(CFG_G_SQUARED, $urandom_range(1000, 8000));
        endcase
        case ($urandom_range(0, 7))
            0: write_reg(CFG_ACCEL_THR, 0);
            1: write_reg(CFG_ACCEL_THR, 49152);
            2: write_reg(CFG_ACCEL_THR, 65535);
            default: write_reg(CFG_ACCEL_THR, $urandom_range(0, 20000));
        endcase
        write_reg(CFG_FIRST_ORDER, $urandom_range(0, 1));
    endtask

    task automatic test_reset_state();
        send_sample(sample_of(16'h0000, 16'h0000, 16'h0000, 0));
        send_sample(sample_of(16'h1000, 16'h0000, 16'h3F00, 100));
        send_sample(sample_of(16'h7FFF, 16'h8000, 16'h0000, 32767));
        send_sample(sample_of(16'h0000, 16'h0000, 16'h0000, 32767));
        send_sample(sample_of(16'h80FF, 16'h0000, 16'h0000, -32768));
        send_sample(sample_of(16'hF0FF, 16'h00FF, 16'hFFFF, -1));
    endtask

    task automatic test_register_extremes();
        // zero divisor and zero g squared, full accelerometer weight
        wait_drained();
        write_reg(CFG_ACCEL_THR, 65535);
        write_reg(CFG_ALPHA, BLEND_FULL);
        write_reg(CFG_G_SQUARED, 0);
        write_reg(CFG_GYRO_DIV, 0);
        send_sample(sample_of(16'h7F00, 16'h0000, 16'h0000, 1000));
        send_sample(sample_of(16'h8000, 16'h00FF, 16'h0000, -1000));
        send_sample(sample_of(16'h7FFF, 16'h7FFF, 16'h7FFF, 0));
        send_sample(sample_of(16'h8000, 16'h8000, 16'h8000, 0));
        // alpha above full scale, first order, magnitude right at threshold
        wait_drained();
        write_reg(CFG_ALPHA, 1023);
        write_reg(CFG_FIRST_ORDER, 1);
        write_reg(CFG_ACCEL_THR, 49152);
        send_sample(sample_of(16'h8000, 16'h0000, 16'h0000, 0));
        send_sample(sample_of(16'h8000, 16'h8000, 16'h8000, 0));
        send_sample(sample_of(16'h7F00, 16'h8000, 16'h8000, 5));
        // gyro only, largest divisor
        wait_drained();
        write_reg(CFG_ALPHA, 0);
        write_reg(CFG_ACCEL_THR, 0);
        write_reg(CFG_GYRO_DIV, 32767);
        send_sample(sample_of(16'h0000, 16'h0000, 16'h0000, 32767));
        send_sample(sample_of(16'h0000, 16'h0000, 16'h0000, -32768));
        send_sample(sample_of(16'hFFFF, 16'hFFFF, 16'hFFFF, 32766));
        // mid settings, second order
        wait_drained();
        write_reg(CFG_ALPHA, 256);
        write_reg(CFG_FIRST_ORDER, 0);
        write_reg(CFG_G_SQUARED, 16384);
        write_reg(CFG_GYRO_DIV, 3);
        write_reg(CFG_ACCEL_THR, 5953);
        send_sample(sample_of(16'h4000, 16'h0000, 16'h3000, -7));
        send_sample(sample_of(16'h3000, 16'h0000, 16'h3000, -7));
        send_sample(sample_of(16'hC0FF, 16'h0000, 16'h3F00, 7));
        send_sample(sample_of(16'hD000, 16'h0000, 16'h3000, -32768));
        wait_drained();
        write_reg(CFG_G_SQUARED, 32767);
        send_sample(sample_of(16'h2000, 16'h0000, 16'h0000, 100));
    endtask

    task automatic test_random_traffic();
        for (int p = 0; p < PHASES; p++) begin
            wait_drained();
            randomize_config();
            for (int k = 0; k < PHASE_WORDS; k++) begin
                if (k % 40 == 0) begin
                    calm = ($urandom_range(0, 3) == 0);
                end
                if (p == 2 && k == 60) begin
                    wait_drained();
                end
                send_sample(rand_sample());
            end
        end
        calm = 1'b0;
    endtask

    initial begin
        int n;
        i_stall <= 1'b0;
        forever begin
            if ($urandom_range(0, 49) == 0) begin
                i_stall <= 1'b0;
                repeat (200) @(posedge i_clk);
            end else begin
                n = idle_len();
                i_stall <= (n > 0);
                repeat ((n > 0) ? n : 1) @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        t_out_word want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pitch_expected.size() == 0) begin
                note_mismatch("unexpected word, pitch", 0, longint'(o_data.pitch));
            end else begin
                want = pitch_expected.pop_front();
                if (o_data.pitch !== want.pitch) begin
                    note_mismatch("pitch", longint'(want.pitch), longint'(o_data.pitch));
                end
                if (o_data.accel_used !== want.accel_used) begin
                    note_mismatch("accel_used", longint'(want.accel_used),
                                  longint'(o_data.accel_used));
                end
            end
        end
    end

    initial begin
        #20ms;
        $display("FAIL complementary_pitch_filter");
        $finish;
    end

    initial begin
        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_data      <= '0;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data  <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_state();
        test_register_extremes();
        test_random_traffic();
        wait_drained();
        if (mismatch_count == 0) begin
            $display("PASS complementary_pitch_filter");
        end else begin
            $display("FAIL complementary_pitch_filter");
        end
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+rtl/core
rtl/core/cpf_pkg.sv
rtl/core/cpf_div.sv
rtl/core/cpf_datapath.sv
rtl/core/cpf_ctrl.sv
rtl/core/complementary_pitch_filter.sv
rtl/core/cpf_checker.sv
tb/sv/tb_top.sv
